// File: rtl/nwrd_pkg.sv
// ----------------------------------------------------------------------------
// nwrd_pkg
// Shared widths, constants, register map and types of the non-wear run
// detector.
// ----------------------------------------------------------------------------
package nwrd_pkg;

    localparam int MAX_RECORD_MINUTES = 131072;
    localparam int INDEX_W            = $clog2(MAX_RECORD_MINUTES);

    localparam int COUNT_W   = 16;
    localparam int MINUTES_W = 11;
    localparam int START_W   = 17;

    localparam int DAY_MINUTES = 1440;

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_WINDOW    = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_TOLERANCE = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_UPPER     = REG_IDX_W'(2);

    localparam logic [MINUTES_W-1:0] WINDOW_RESET    = MINUTES_W'(60);
    localparam logic [MINUTES_W-1:0] TOLERANCE_RESET = MINUTES_W'(2);
    localparam logic [COUNT_W-1:0]   UPPER_RESET     = COUNT_W'(100);

    typedef struct packed {
        logic [MINUTES_W-1:0] window_minutes;
        logic [MINUTES_W-1:0] tolerance_minutes;
        logic [COUNT_W-1:0]   upper_count;
    } cfg_t;

endpackage

// File: rtl/nwrd_if.sv
// ----------------------------------------------------------------------------
// nwrd_sample_if / nwrd_run_if
// Valid/ready channels for minute samples and detected runs.
// ----------------------------------------------------------------------------
interface nwrd_sample_if;
    import nwrd_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] activity_count;
    logic               record_end;

    modport source (output valid, output activity_count, output record_end, input ready);
    modport sink   (input valid, input activity_count, input record_end, output ready);
endinterface

interface nwrd_run_if;
    import nwrd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [START_W-1:0]   run_start;
    logic [MINUTES_W-1:0] run_length;

    modport source (output valid, output run_start, output run_length, input ready);
    modport sink   (input valid, input run_start, input run_length, output ready);
endinterface

// File: rtl/nwrd_cfg.sv
// ----------------------------------------------------------------------------
// nwrd_cfg
// APB register file: window, tolerance and upper count limit.
// ----------------------------------------------------------------------------
module nwrd_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nwrd_pkg::ADDR_W-1:0] paddr,
    input  logic [nwrd_pkg::DATA_W-1:0] pwdata,
    output logic [nwrd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output nwrd_pkg::cfg_t              cfg
);
    import nwrd_pkg::*;

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_minutes    <= WINDOW_RESET;
            cfg_reg.tolerance_minutes <= TOLERANCE_RESET;
            cfg_reg.upper_count       <= UPPER_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_WINDOW:    cfg_reg.window_minutes    <= pwdata[MINUTES_W-1:0];
                REG_TOLERANCE: cfg_reg.tolerance_minutes <= pwdata[MINUTES_W-1:0];
                REG_UPPER:     cfg_reg.upper_count       <= pwdata[COUNT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WINDOW:    prdata = DATA_W'(cfg_reg.window_minutes);
            REG_TOLERANCE: prdata = DATA_W'(cfg_reg.tolerance_minutes);
            REG_UPPER:     prdata = DATA_W'(cfg_reg.upper_count);
            default:       prdata = '0;
        endcase
    end

endmodule

// File: rtl/nwrd_core.sv
// ----------------------------------------------------------------------------
// nwrd_core
// Run tracking state, close decision and a two-word result buffer.
// ----------------------------------------------------------------------------
module nwrd_core (
    input  logic           clk,
    input  logic           rst_n,
    input  nwrd_pkg::cfg_t cfg,
    nwrd_sample_if.sink    samples,
    nwrd_run_if.source     runs
);
    import nwrd_pkg::*;

    localparam int SUM_W = ((INDEX_W > MINUTES_W) ? INDEX_W : MINUTES_W) + 1;
    localparam logic [INDEX_W-1:0]   INDEX_LAST   = INDEX_W'(MAX_RECORD_MINUTES - 1);
    localparam logic [MINUTES_W-1:0] DAY_LAST     = MINUTES_W'(DAY_MINUTES - 1);

    logic [MINUTES_W-1:0] run_reg, run_next;
    logic [MINUTES_W-1:0] streak_reg, streak_next;
    logic [INDEX_W-1:0]   index_reg, index_next;
    logic [MINUTES_W-1:0] day_reg, day_next;

    logic                 out_valid_reg, skid_valid_reg;
    logic [START_W-1:0]   out_start_reg, skid_start_reg;
    logic [MINUTES_W-1:0] out_len_reg, skid_len_reg;

    logic                 take;
    logic                 count_zero;
    logic                 active;
    logic                 over;
    logic                 day_last;
    logic                 close_run;
    logic                 emit;
    logic                 pop;
    logic [MINUTES_W-1:0] run_inc;
    logic [MINUTES_W-1:0] streak_inc;
    logic [MINUTES_W-1:0] len;
    logic [MINUTES_W-1:0] need;
    logic [SUM_W-1:0]     idx_plus;
    logic [SUM_W-1:0]     run_ext;
    logic [SUM_W-1:0]     start_full;
    logic [SUM_W+START_W-1:0] start_wide;
    logic [START_W-1:0]   start;

    assign samples.ready = !skid_valid_reg;
    assign take          = samples.valid && samples.ready;
    assign pop           = out_valid_reg && runs.ready;

    always_comb
    begin
        count_zero = (samples.activity_count == '0);
        active     = (run_reg != '0) || count_zero;
        day_last   = (day_reg == DAY_LAST);
        run_inc    = run_reg + MINUTES_W'(1);
        streak_inc = count_zero ? '0 : streak_reg + MINUTES_W'(1);
        over       = !count_zero && (samples.activity_count > cfg.upper_count);
        close_run  = active && ((streak_inc > cfg.tolerance_minutes) || over
                               || samples.record_end || day_last);
        len        = run_inc - streak_inc;
        need       = (cfg.window_minutes == '0) ? MINUTES_W'(1) : cfg.window_minutes;
        emit       = close_run && (len >= need);

        idx_plus   = SUM_W'(index_reg) + SUM_W'(1);
        run_ext    = SUM_W'(run_inc);
        start_full = (idx_plus >= run_ext) ? idx_plus - run_ext : '0;
        start_wide = {{START_W{1'b0}}, start_full};
        start      = start_wide[START_W-1:0];

        if (!active || samples.record_end)
        begin
            run_next    = samples.record_end ? '0 : run_reg;
            streak_next = samples.record_end ? '0 : streak_reg;
        end
        else if (close_run)
        begin
            run_next    = '0;
            streak_next = '0;
        end
        else
        begin
            run_next    = run_inc;
            streak_next = streak_inc;
        end

        if (samples.record_end)
        begin
            index_next = '0;
            day_next   = '0;
        end
        else
        begin
            index_next = (index_reg < INDEX_LAST) ? index_reg + INDEX_W'(1) : index_reg;
            day_next   = day_last ? '0 : day_reg + MINUTES_W'(1);
        end
    end

    // record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= '0;
            streak_reg <= '0;
            index_reg  <= '0;
            day_reg    <= '0;
        end
        else if (take)
        begin
            run_reg    <= run_next;
            streak_reg <= streak_next;
            index_reg  <= index_next;
            day_reg    <= day_next;
        end
    end

    // result buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= take && emit;
            end
        end
        else if (take && emit)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_start_reg <= skid_start_reg;
                out_len_reg   <= skid_len_reg;
            end
            else
            begin
                out_start_reg <= start;
                out_len_reg   <= len;
            end
        end
        else if (take && emit)
        begin
            if (out_valid_reg)
            begin
                skid_start_reg <= start;
                skid_len_reg   <= len;
            end
            else
            begin
                out_start_reg <= start;
                out_len_reg   <= len;
            end
        end
    end

    assign runs.valid      = out_valid_reg;
    assign runs.run_start  = out_start_reg;
    assign runs.run_length = out_len_reg;

endmodule

// File: rtl/nonwear_run_detector.sv
// ----------------------------------------------------------------------------
// nonwear_run_detector
// Finds non-wear runs in a stream of per-minute activity counts.
// ----------------------------------------------------------------------------
// a run word is registered into the result buffer when the minute that closes it is accepted
// throughput: one minute word per cycle while the result buffer is not full, set by the state update
// a two-word result buffer keeps samples flowing while one run word waits
// reset: asynchronous, clears the record state and the result buffer and
// loads the register defaults (window 60, tolerance 2, upper count 100)
module nonwear_run_detector (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nwrd_pkg::ADDR_W-1:0] paddr,
    input  logic [nwrd_pkg::DATA_W-1:0] pwdata,
    output logic [nwrd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    nwrd_sample_if.sink                 samples,
    nwrd_run_if.source                  runs
);
    import nwrd_pkg::*;

    cfg_t cfg;

    nwrd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nwrd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .samples (samples),
        .runs    (runs)
    );

endmodule

// File: rtl/nwrd_checker.sv
// ----------------------------------------------------------------------------
// nwrd_checker
// Port-level checks of the non-wear run detector, bound to the top level.
// ----------------------------------------------------------------------------
module nwrd_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nwrd_pkg::ADDR_W-1:0]    paddr,
    input  logic [nwrd_pkg::DATA_W-1:0]    pwdata,
    input  logic [nwrd_pkg::DATA_W-1:0]    prdata,
    input  logic                           pready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [nwrd_pkg::START_W-1:0]   run_start,
    input  logic [nwrd_pkg::MINUTES_W-1:0] run_length
);
    import nwrd_pkg::*;

    // a waiting run word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(run_start) && $stable(run_length))
        else $error("run word changed while stalled");

    // a run never has zero length and never spans more than one day
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> run_length != '0 && run_length <= MINUTES_W'(DAY_MINUTES))
        else $error("run length out of range");

    // window register reads back what was written
    a_window_rb: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_WINDOW
        |=> !psel || pwrite || paddr[ADDR_W-1:2] != REG_WINDOW
            || prdata == DATA_W'($past(pwdata[MINUTES_W-1:0])))
        else $error("window register readback mismatch");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind nonwear_run_detector nwrd_checker u_nwrd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .out_valid  (runs.valid),
    .out_ready  (runs.ready),
    .run_start  (runs.run_start),
    .run_length (runs.run_length)
);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for nonwear_run_detector. A minute-level predictor
// follows every accepted minute word and queues the run words it implies;
// the monitor matches each run word against that queue. Directed minutes
// cover the special cases, random minutes mix well-formed runs with noise
// under several register settings, and one record runs a full day of zeros
// so that the day boundary closes a run of the largest length.
// ----------------------------------------------------------------------------
module testbench;
    import nwrd_pkg::*;

    localparam int IDLE_LIMIT       = 4000;
    localparam int HOLD_CYCLES      = 300;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = REG_IDX_W'(3);

    typedef struct packed {
        logic [START_W-1:0]   run_start;
        logic [MINUTES_W-1:0] run_length;
    } run_word_t;

    class nonwear_tracker;
        bit [MINUTES_W-1:0] window;
        bit [MINUTES_W-1:0] tolerance;
        bit [COUNT_W-1:0]   upper;
        bit [MINUTES_W-1:0] run_minutes;
        bit [MINUTES_W-1:0] streak;
        bit [START_W-1:0]   minute_index;
        bit [MINUTES_W-1:0] minute_of_day;
        run_word_t          runs_due[$];
        int                 errors;
        int                 runs_matched;
        int                 minutes_seen;
        int                 minutes_in_runs;
        int                 top_index;

        function new();
            window    = WINDOW_RESET;
            tolerance = TOLERANCE_RESET;
            upper     = UPPER_RESET;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_WINDOW:    window    = value[MINUTES_W-1:0];
                REG_TOLERANCE: tolerance = value[MINUTES_W-1:0];
                REG_UPPER:     upper     = value[COUNT_W-1:0];
                default:       ;
            endcase
        endfunction

        function logic [DATA_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
            case (idx)
                REG_WINDOW:    return DATA_W'(window);
                REG_TOLERANCE: return DATA_W'(tolerance);
                REG_UPPER:     return DATA_W'(upper);
                default:       return '0;
            endcase
        endfunction

        function void take_minute(logic [COUNT_W-1:0] cnt, logic last);
            bit          day_last;
            bit          over;
            int unsigned kept;
            int unsigned need;
            int unsigned first;
            day_last = (minute_of_day == DAY_MINUTES - 1);
            minutes_seen++;
            if (run_minutes != 0 || cnt == 0) begin
                minutes_in_runs++;
                over = 1'b0;
                run_minutes++;
                if (cnt == 0) begin
                    streak = '0;
                end
                else begin
                    streak++;
                    over = (cnt > upper);
                end
                if (streak > tolerance || over || last || day_last) begin
                    kept = run_minutes - streak;
                    need = (window == 0) ? 1 : window;
                    if (kept >= need) begin
                        first = (minute_index + 1 >= run_minutes) ?
                                minute_index + 1 - run_minutes : 0;
                        runs_due.push_back('{run_start: START_W'(first),
                                             run_length: MINUTES_W'(kept)});
                    end
                    run_minutes = '0;
                    streak      = '0;
                end
            end
            if (last) begin
                run_minutes   = '0;
                streak        = '0;
                minute_index  = '0;
                minute_of_day = '0;
            end
            else begin
                if (minute_index < MAX_RECORD_MINUTES - 1)
                    minute_index++;
                if (minute_index > top_index)
                    top_index = minute_index;
                minute_of_day = day_last ? '0 : minute_of_day + 1'b1;
            end
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR at %0t: %s", $time, msg);
        endtask

        task match_run(logic [START_W-1:0] got_start, logic [MINUTES_W-1:0] got_length);
            run_word_t want;
            runs_matched++;
            if (runs_due.size() == 0) begin
                report($sformatf("run word with none due: start %0d length %0d",
                                 got_start, got_length));
            end
            else begin
                want = runs_due.pop_front();
                if (got_start !== want.run_start)
                    report($sformatf("run_start %0d, expected %0d",
                                     got_start, want.run_start));
                if (got_length !== want.run_length)
                    report($sformatf("run_length %0d, expected %0d",
                                     got_length, want.run_length));
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    nwrd_sample_if sif ();
    nwrd_run_if    rif ();

    nonwear_tracker tracker = new();

    bit no_idle;
    int hold_left;
    int settings_done;

    nonwear_run_detector DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (sif),
        .runs    (rif)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run word receiver with random stalls and an optional long hold-off
    initial
    begin
        rif.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rif.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rif.ready <= no_idle || ($urandom_range(99) >= 12);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rif.valid && rif.ready)
            tracker.match_run(rif.run_start, rif.run_length);
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((sif.valid && sif.ready) || (rif.valid && rif.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_minute(input logic [COUNT_W-1:0] cnt, input logic last);
        while (!no_idle && $urandom_range(99) < 12)
        begin
            sif.valid <= 1'b0;
            @(posedge clk);
        end
        sif.valid          <= 1'b1;
        sif.activity_count <= cnt;
        sif.record_end     <= last;
        @(posedge clk);
        while (!sif.ready)
            @(posedge clk);
        tracker.take_minute(cnt, last);
    endtask

    task automatic wait_idle();
        sif.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.runs_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic apb_check(input logic [REG_IDX_W-1:0] idx);
        logic [DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== tracker.reg_value(idx))
            tracker.report($sformatf("register %0d reads %0h, expected %0h",
                                     idx, got, tracker.reg_value(idx)));
    endtask

    task automatic set_limits(input logic [DATA_W-1:0] win, input logic [DATA_W-1:0] tol,
                              input logic [DATA_W-1:0] up);
        wait_idle();
        apb_write(REG_WINDOW, win);
        apb_write(REG_TOLERANCE, tol);
        apb_write(REG_UPPER, up);
        apb_check(REG_WINDOW);
        apb_check(REG_TOLERANCE);
        apb_check(REG_UPPER);
        settings_done++;
    endtask

    function automatic logic [COUNT_W-1:0] low_count();
        return (tracker.upper == 0) ? COUNT_W'(1) : COUNT_W'($urandom_range(tracker.upper, 1));
    endfunction

    function automatic logic [COUNT_W-1:0] high_count();
        return (tracker.upper == 16'hFFFF) ? 16'hFFFF :
               COUNT_W'($urandom_range(65535, tracker.upper + 1));
    endfunction

    task automatic send_low_burst(input int n);
        repeat (n) send_minute(low_count(), 1'b0);
    endtask

    // mostly zero runs near the window with low-count bursts, then noise
    task automatic random_minutes(input int target);
        int goal;
        int hi;
        int lo;
        int cap;
        int pick;
        goal = tracker.minutes_in_runs + target;
        while (tracker.minutes_in_runs < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                hi  = (tracker.window + 3 > 60) ? 60 : tracker.window + 3;
                lo  = (hi > 7) ? hi - 6 : 1;
                cap = (tracker.tolerance + 1 > 6) ? 6 : tracker.tolerance + 1;
                repeat ($urandom_range(hi, lo))
                begin
                    send_minute(COUNT_W'(0), 1'b0);
                    if ($urandom_range(99) < 12)
                        send_low_burst($urandom_range(cap, 1));
                end
                case ($urandom_range(3))
                    0: send_minute(high_count(), 1'b0);
                    1: send_minute($urandom_range(1) ? COUNT_W'(0) : low_count(), 1'b1);
                    2: send_low_burst((tracker.tolerance + 1 > 8) ? 8 : tracker.tolerance + 1);
                    default: ;
                endcase
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(8, 1))
                    send_minute(COUNT_W'($urandom()), $urandom_range(99) < 3);
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                    send_minute(high_count(), 1'b0);
            end
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        sif.valid          <= 1'b0;
        sif.activity_count <= '0;
        sif.record_end     <= 1'b0;
        no_idle            = 1'b0;
        hold_left          = 0;
        settings_done      = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_check(REG_WINDOW);
        apb_check(REG_TOLERANCE);
        apb_check(REG_UPPER);

        // window zero acts as one, upper zero closes on any nonzero count
        set_limits(32'd0, 32'd1, 32'd0);
        send_minute(16'hFFFF, 1'b0);
        send_minute(16'd5, 1'b0);
        send_minute(16'd0, 1'b0);
        send_minute(16'd0, 1'b0);
        send_minute(16'd1, 1'b0);
        send_minute(16'd0, 1'b1);
        send_minute(16'd0, 1'b0);
        send_minute(16'd0, 1'b0);
        send_minute(16'd0, 1'b0);
        send_minute(16'hFFFF, 1'b0);
        send_minute(16'h8000, 1'b1);

        // tolerated streaks, streak overflow and record end
        set_limits(32'd3, 32'd2, 32'h0000_FFFF);
        send_minute(16'd0, 1'b0);
        send_minute(16'hFFFF, 1'b0);
        send_minute(16'hFFFF, 1'b0);
        send_minute(16'd0, 1'b0);
        send_minute(16'd0, 1'b0);
        send_minute(16'h7FFF, 1'b0);
        send_minute(16'h7FFF, 1'b0);
        send_minute(16'h7FFF, 1'b0);
        send_minute(16'd0, 1'b0);
        send_minute(16'd0, 1'b0);
        send_minute(16'd1, 1'b0);
        send_minute(16'd1, 1'b1);
        send_minute(16'd0, 1'b0);
        send_minute(16'd0, 1'b0);
        send_minute(16'd0, 1'b1);

        set_limits(32'd5, 32'd2, 32'd100);
        random_minutes(40);

        // receiver holds off while short runs keep coming
        set_limits(32'd1, 32'd0, 32'd0);
        hold_left = HOLD_CYCLES;
        no_idle   = 1'b1;
        repeat (40)
        begin
            send_minute(16'd0, 1'b0);
            send_minute(16'd1, 1'b0);
        end
        no_idle = 1'b0;
        random_minutes(40);

        // upper bits of each write are dropped by the register
        set_limits(32'hFFFF_F800, 32'hFFFF_F803, 32'hFFFF_FFFF);
        no_idle = 1'b1;
        random_minutes(40);
        no_idle = 1'b0;

        // a full day of zeros reaches the largest window
        set_limits(32'd1440, 32'd1440, 32'h0000_FFFF);
        send_minute(16'd0, 1'b1);
        repeat (DAY_MINUTES) send_minute(16'd0, 1'b0);

        wait_idle();
        apb_write(REG_UNUSED, 32'd1);
        set_limits(32'd12, 32'd4, 32'd30);
        random_minutes(40);

        wait_idle();
        repeat (10) @(posedge clk);
        if (tracker.runs_due.size() != 0)
            tracker.report($sformatf("%0d run words never arrived", tracker.runs_due.size()));

        $display("covered %0d minute words (%0d inside runs) under %0d register settings",
                 tracker.minutes_seen, tracker.minutes_in_runs, settings_done);
        $display("matched %0d run words; highest minute index %0d; %0d mismatches",
                 tracker.runs_matched, tracker.top_index, tracker.errors);
        if (tracker.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
